FILE: sv/cpak_pkg.sv
// shared constants of the color/position affinity kernel
package cpak_pkg;

   // ln2 in Q.32, rounded to nearest
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   // channel magnitude in Q.16 and its square sums
   localparam int MAG_W = 25;
   localparam int SUM_W = 52;
   // square root working width and result width
   localparam int SQ_W = SUM_W + 1;
   localparam int ROOT_W = 26;
   // product beta * norm, and the in-range part below 32.0 in Q.32
   localparam int PROD_W = 50;
   localparam int T_W = 37;
   // quotient of the ln2 reduction
   localparam int K_W = 6;
   // number of Horner steps of the exp series
   localparam int SERIES_TERMS = 14;
   // reciprocal scale for division by a term index
   localparam int RCP_SH = 35;
   localparam int RCP_W = RCP_SH + 1;
   // scaled result before flush and saturation
   localparam int RES_W = 41;
   localparam logic [31:0] DEC_BILLION = 32'd1000000000;

endpackage

FILE: sv/color_position_affinity_kernel.sv
// top level of the color/position affinity kernel
//
// Input items arrive on the req_ stream: two RGB pixels and their
// (x,y) positions in unsigned Q0.COORD_FRAC_BITS. Each item gives one result
// item on the rsp_ stream: exp(-beta*norm) in unsigned Q1.OUT_FRAC_BITS,
// flushed to zero below 1e-9. beta is written through csr_wen/csr_wdata
// (unsigned Q8.16) while no item is in flight.
// Throughput: one item per cycle while the skid register is empty. The path
// from the accept edge to rsp_tvalid runs through 82 register stages:
// 5 front stages, 26 square-root bit stages, one multiply stage, 6 ln2
// reduction stages, 42 series stages (three per Horner step), one scaling
// stage and the output register.
// A skid register behind the output register takes the item that is
// already on its way when the receiver stalls; while the skid register is
// full the whole pipeline holds and req_tready is low, so nothing is lost
// or repeated. req_tready comes straight from a flip-flop.
// Reset clears all valid bits, empties output and skid registers and sets
// beta to 1.0; no clearing pass is needed.
module color_position_affinity_kernel #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int OUT_FRAC_BITS = 31
) (
   input  logic         clock,
   input  logic         reset,
   // config register: decay_rate
   input  logic         csr_wen,
   input  logic [23:0]  csr_wdata,
   // req item
   input  logic         req_tvalid,
   output logic         req_tready,
   // red_a, green_a, blue_a, red_b, green_b, blue_b, col_a, row_a, col_b, row_b
   input  logic [111:0] req_tdata,
   // rsp item
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // affinity
   output logic [31:0]  rsp_tdata
);

   localparam int CW = (COORD_FRAC_BITS > 16) ? 16 : COORD_FRAC_BITS;
   localparam int SW = COORD_FRAC_BITS + 10;
   localparam int HS = 3 * cpak_pkg::SERIES_TERMS;
   // stage offsets of the valid chain
   localparam int V_SQ = 5;
   localparam int V_MUL = V_SQ + cpak_pkg::ROOT_W;
   localparam int V_DIV = V_MUL + 1;
   localparam int V_HOR = V_DIV + cpak_pkg::K_W;
   localparam int V_SHF = V_HOR + HS;
   localparam int NSTG = V_SHF + 1;
   localparam longint unsigned TINY_LIM =
      ((64'd1 << OUT_FRAC_BITS) + 64'd999999999) / 64'd1000000000;

   logic adv;
   logic [NSTG-1:0] vld_ff;
   logic [23:0] beta_ff;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= 24'd65536;
      end else if (csr_wen) begin
         beta_ff <= csr_wdata;
      end
   end

   // valid chain, moves whenever the skid register is empty
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
      end
   end

   assign req_tready = adv;

   // stage 0: position sum and channel differences
   logic signed [CW+1:0] d1_ff;
   logic signed [8:0] df1_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= $signed({2'b0, req_tdata[48 +: CW]}) - $signed({2'b0, req_tdata[80 +: CW]})
                + $signed({2'b0, req_tdata[64 +: CW]}) - $signed({2'b0, req_tdata[96 +: CW]});
         for (int c = 0; c < 3; c++) begin
            df1_ff[c] <= $signed({1'b0, req_tdata[8*c +: 8]})
                       - $signed({1'b0, req_tdata[8*c+24 +: 8]});
         end
      end
   end

   // stage 1: channel sums with the position term
   logic [CW+1:0] pos;
   logic signed [SW-1:0] s2_ff [3];
   assign pos = d1_ff[CW+1] ? (CW+2)'(-d1_ff) : d1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            s2_ff[c] <= (SW'(df1_ff[c]) <<< COORD_FRAC_BITS) + $signed(SW'(pos));
         end
      end
   end

   // stage 2: magnitudes brought to Q.16
   logic [cpak_pkg::MAG_W-1:0] m3_ff [3];
   logic [SW-1:0] sabs [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sabs[c] = s2_ff[c][SW-1] ? SW'(-s2_ff[c]) : SW'(s2_ff[c]);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            if (COORD_FRAC_BITS > 16) begin
               m3_ff[c] <= cpak_pkg::MAG_W'(sabs[c] >> (COORD_FRAC_BITS - 16));
            end else begin
               m3_ff[c] <= cpak_pkg::MAG_W'(sabs[c]) << (16 - COORD_FRAC_BITS);
            end
         end
      end
   end

   // stage 3: squares
   logic [2*cpak_pkg::MAG_W-1:0] sq4_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            sq4_ff[c] <= {{cpak_pkg::MAG_W{1'b0}}, m3_ff[c]}
                       * {{cpak_pkg::MAG_W{1'b0}}, m3_ff[c]};
         end
      end
   end

   // stage 4: sum of squares
   logic [cpak_pkg::SUM_W-1:0] sum5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sum5_ff <= cpak_pkg::SUM_W'(sq4_ff[0]) + cpak_pkg::SUM_W'(sq4_ff[1])
                  + cpak_pkg::SUM_W'(sq4_ff[2]);
      end
   end

   // square root, one result bit per stage
   logic [cpak_pkg::SQ_W-1:0] sv_ff [cpak_pkg::ROOT_W];
   logic [cpak_pkg::SQ_W-1:0] sr_ff [cpak_pkg::ROOT_W];
   for (genvar i = 0; i < cpak_pkg::ROOT_W; i++) begin : g_sqrt
      localparam logic [cpak_pkg::SQ_W-1:0] BIT =
         cpak_pkg::SQ_W'(1) << (2 * (cpak_pkg::ROOT_W - 1 - i));
      logic [cpak_pkg::SQ_W-1:0] v_in, r_in, trial;
      if (i == 0) begin : g_first
         assign v_in = cpak_pkg::SQ_W'(sum5_ff);
         assign r_in = '0;
      end else begin : g_next
         assign v_in = sv_ff[i-1];
         assign r_in = sr_ff[i-1];
      end
      assign trial = r_in + BIT;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (v_in >= trial) begin
               sv_ff[i] <= v_in - trial;
               sr_ff[i] <= (r_in >> 1) + BIT;
            end else begin
               sv_ff[i] <= v_in;
               sr_ff[i] <= r_in >> 1;
            end
         end
      end
   end

   // exponent t = beta * norm, with the huge flag
   logic [cpak_pkg::PROD_W-1:0] prod;
   logic [cpak_pkg::T_W-1:0] t_ff;
   logic hg_ff;
   assign prod = cpak_pkg::PROD_W'(beta_ff)
               * cpak_pkg::PROD_W'(sr_ff[cpak_pkg::ROOT_W-1][cpak_pkg::ROOT_W-1:0]);
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff <= prod[cpak_pkg::T_W-1:0];
         hg_ff <= |prod[cpak_pkg::PROD_W-1:cpak_pkg::T_W];
      end
   end

   // reduction by ln2, one quotient bit per stage
   logic [cpak_pkg::T_W-1:0] dr_ff [cpak_pkg::K_W];
   logic [cpak_pkg::K_W-1:0] dk_ff [cpak_pkg::K_W];
   logic dh_ff [cpak_pkg::K_W];
   for (genvar j = 0; j < cpak_pkg::K_W; j++) begin : g_div
      localparam logic [cpak_pkg::T_W-1:0] STEP =
         cpak_pkg::T_W'(cpak_pkg::LN2_Q32) << (cpak_pkg::K_W - 1 - j);
      logic [cpak_pkg::T_W-1:0] r_in;
      logic [cpak_pkg::K_W-1:0] k_in;
      logic h_in;
      if (j == 0) begin : g_first
         assign r_in = t_ff;
         assign k_in = '0;
         assign h_in = hg_ff;
      end else begin : g_next
         assign r_in = dr_ff[j-1];
         assign k_in = dk_ff[j-1];
         assign h_in = dh_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dh_ff[j] <= h_in;
            if (r_in >= STEP) begin
               dr_ff[j] <= r_in - STEP;
               dk_ff[j] <= k_in | (cpak_pkg::K_W'(1) << (cpak_pkg::K_W - 1 - j));
            end else begin
               dr_ff[j] <= r_in;
               dk_ff[j] <= k_in;
            end
         end
      end
   end

   // exp(-r) by Horner steps, three stages each
   logic [31:0] cr_ff [HS];
   logic [cpak_pkg::K_W-1:0] ck_ff [HS];
   logic ch_ff [HS];
   logic [31:0] hp_ff [cpak_pkg::SERIES_TERMS];
   logic [31:0] hpb_ff [cpak_pkg::SERIES_TERMS];
   logic [31:0] hq_ff [cpak_pkg::SERIES_TERMS];
   logic [32:0] hacc_ff [cpak_pkg::SERIES_TERMS];
   for (genvar h = 0; h < cpak_pkg::SERIES_TERMS; h++) begin : g_hor
      localparam int N = cpak_pkg::SERIES_TERMS - h;
      localparam logic [cpak_pkg::RCP_W-1:0] RCP =
         cpak_pkg::RCP_W'((64'd1 << cpak_pkg::RCP_SH) / N);
      logic [31:0] r_in;
      logic [cpak_pkg::K_W-1:0] k_in;
      logic h_in;
      logic [32:0] acc_in;
      logic [64:0] pa;
      logic [cpak_pkg::RCP_W+31:0] pb;
      logic [35:0] qn, rem;
      if (h == 0) begin : g_first
         assign r_in = dr_ff[cpak_pkg::K_W-1][31:0];
         assign k_in = dk_ff[cpak_pkg::K_W-1];
         assign h_in = dh_ff[cpak_pkg::K_W-1];
         assign acc_in = 33'h1_0000_0000;
      end else begin : g_next
         assign r_in = cr_ff[3*h-1];
         assign k_in = ck_ff[3*h-1];
         assign h_in = ch_ff[3*h-1];
         assign acc_in = hacc_ff[h-1];
      end
      assign pa = 65'(r_in) * 65'(acc_in);
      assign pb = (cpak_pkg::RCP_W+32)'(hp_ff[h]) * (cpak_pkg::RCP_W+32)'(RCP);
      assign qn = 36'(hq_ff[h]) * 36'(N);
      assign rem = 36'(hpb_ff[h]) - qn;
      always_ff @(posedge clock) begin
         if (adv) begin
            // product r * acc, upper word
            hp_ff[h] <= pa[63:32];
            cr_ff[3*h] <= r_in;
            ck_ff[3*h] <= k_in;
            ch_ff[3*h] <= h_in;
            // quotient estimate by reciprocal
            hq_ff[h] <= pb[cpak_pkg::RCP_SH +: 32];
            hpb_ff[h] <= hp_ff[h];
            cr_ff[3*h+1] <= cr_ff[3*h];
            ck_ff[3*h+1] <= ck_ff[3*h];
            ch_ff[3*h+1] <= ch_ff[3*h];
            // quotient correction and new accumulator
            if (rem >= 36'(N)) begin
               hacc_ff[h] <= 33'h1_0000_0000 - 33'(hq_ff[h]) - 33'd1;
            end else begin
               hacc_ff[h] <= 33'h1_0000_0000 - 33'(hq_ff[h]);
            end
            cr_ff[3*h+2] <= cr_ff[3*h+1];
            ck_ff[3*h+2] <= ck_ff[3*h+1];
            ch_ff[3*h+2] <= ch_ff[3*h+1];
         end
      end
   end

   // scaling by 2^-k to the output format, rounded half up
   logic signed [7:0] shamt;
   logic [63:0] wide, scaled;
   logic [cpak_pkg::RES_W-1:0] res_ff;
   assign shamt = 8'sd32 + $signed({2'b0, ck_ff[HS-1]}) - 8'(OUT_FRAC_BITS);
   assign wide = 64'(hacc_ff[cpak_pkg::SERIES_TERMS-1]);
   always_comb begin
      if (shamt <= 8'sd0) begin
         scaled = wide << 6'(-shamt);
      end else begin
         scaled = (wide + (64'd1 << 6'(shamt - 8'sd1))) >> 6'(shamt);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= ch_ff[HS-1] ? '0 : scaled[cpak_pkg::RES_W-1:0];
      end
   end

   // flush of tiny values and saturation
   logic [31:0] fin;
   always_comb begin
      if (64'(res_ff) < TINY_LIM) begin
         fin = '0;
      end else if (|res_ff[cpak_pkg::RES_W-1:32]) begin
         fin = '1;
      end else begin
         fin = res_ff[31:0];
      end
   end

   // output register with skid register
   logic out_vld_ff, skid_vld_ff;
   logic [31:0] out_data_ff, skid_data_ff;
   assign adv = !skid_vld_ff;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_vld_ff <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (out_vld_ff && !rsp_tready) begin
         skid_vld_ff <= vld_ff[NSTG-1];
      end else begin
         out_vld_ff <= vld_ff[NSTG-1];
      end
   end
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (out_vld_ff && !rsp_tready) begin
         skid_data_ff <= fin;
      end else begin
         out_data_ff <= fin;
      end
   end

`ifndef SYNTHESIS
   // a parked item always has a result in front of it
   assert property (@(posedge clock) disable iff (reset) skid_vld_ff |-> out_vld_ff)
      else $error("skid register full while output register empty");
   // a stalled result keeps the parked item
   assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_tready) |=> (skid_vld_ff && $stable(skid_data_ff)))
      else $error("parked item lost during stall");
   // the series accumulator stays within 1.0
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG-1] |-> (hacc_ff[cpak_pkg::SERIES_TERMS-1] <= 33'h1_0000_0000))
      else $error("series accumulator out of range");
   // the pipeline holds while the skid register is full
   assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff) || !$past(skid_vld_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

FILE: dv/affinity_checker.sv
// checker of the affinity kernel: watches both streams, predicts and compares
`timescale 1ns / 100ps
module affinity_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [23:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   output int           fail_count,
   output int           pending_count
);

   localparam logic [63:0] LN2_FIX = 64'd2977044472;
   localparam logic [63:0] EXP_CAP = 64'd32 << 32;

   logic [23:0] beta_q;
   logic [31:0] affinity_queue[$];

   // magnitude of one channel sum in Q.16
   function automatic logic [63:0] chan_mag(input logic [7:0] pa, input logic [7:0] pb,
                                            input longint pos);
      longint s;
      s = (longint'(pa) - longint'(pb)) * 65536 + pos;
      return (s < 0) ? -s : s;
   endfunction

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // expected affinity for one pixel pair under the current beta
   function automatic logic [31:0] predict_affinity(input logic [111:0] d);
      longint dd, pos;
      logic [63:0] mr, mg, mb, norm, t, k, r, acc, res;
      logic [127:0] prod;
      int n, shift;
      dd = (longint'(d[63:48]) - longint'(d[95:80]))
         + (longint'(d[79:64]) - longint'(d[111:96]));
      pos = dd < 0 ? -dd : dd;
      mr = chan_mag(d[7:0], d[31:24], pos);
      mg = chan_mag(d[15:8], d[39:32], pos);
      mb = chan_mag(d[23:16], d[47:40], pos);
      norm = int_root(mr * mr + mg * mg + mb * mb);
      t = {40'd0, beta_q} * norm;
      if (t >= EXP_CAP) begin
         res = 0;
      end else begin
         k = t / LN2_FIX;
         r = t - k * LN2_FIX;
         acc = 64'd1 << 32;
         for (n = 14; n >= 1; n--) begin
            prod = {64'd0, r} * {64'd0, acc};
            acc = 64'((64'd1 << 32) - ((prod >> 32) / n));
         end
         shift = 1 + int'(k);
         res = (shift >= 64) ? 64'd0 : (acc + (64'd1 << (shift - 1))) >> shift;
      end
      if (res < (64'd1 << 30) && res * 64'd1000000000 < (64'd1 << 31)) res = 0;
      if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
      return res[31:0];
   endfunction

   // predict on req accept, compare on rsp accept
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         beta_q <= 24'd65536;
         affinity_queue.delete();
      end else begin
         if (csr_wen) beta_q <= csr_wdata;
         if (req_tvalid && req_tready) affinity_queue.push_back(predict_affinity(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (affinity_queue.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = affinity_queue.pop_front();
               if (want !== rsp_tdata) begin
                  $display("%0t: affinity mismatch, expected %h actual %h",
                           $time, want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= affinity_queue.size();
   end

endmodule

FILE: dv/tb_top.sv
// testbench top: stimulus, idling, watchdog and verdict for the affinity kernel
`timescale 1ns / 100ps
module tb_top;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_wen = 0;
   logic [23:0]  csr_wdata = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   int           fail_count, pending_count;
   int           quiet_cycles = 0;
   bit           calm_mode = 0;
   bit           hold_off = 0;
   bit           run_done = 0;

   always #5 clock = ~clock;

   color_position_affinity_kernel u_dut (.*);

   affinity_checker u_check (.*);

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 10);
   end

   // watchdog on accept-free cycles
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 2000 && !run_done) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // send one item, with a random gap before it outside calm mode
   task automatic send_item(input logic [111:0] d);
      if (!calm_mode) begin
         while ($urandom_range(99) < 10) begin
            req_tvalid <= 0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [111:0] make_item(input logic [47:0] rgb, input logic [15:0] ca,
                                              input logic [15:0] ra, input logic [15:0] cb,
                                              input logic [15:0] rb);
      return {rb, cb, ra, ca, rgb};
   endfunction

   // random item: mostly small position differences and near colors so exp stays live
   function automatic logic [111:0] rand_item();
      logic [47:0] rgb;
      logic [15:0] ca, ra, cb, rb;
      rgb = 48'({$urandom, $urandom});
      ca = 16'($urandom); ra = 16'($urandom);
      if ($urandom_range(3) != 0) begin
         rgb[31:24] = 8'(rgb[7:0] + $urandom_range(6) - 3);
         rgb[39:32] = 8'(rgb[15:8] + $urandom_range(6) - 3);
         rgb[47:40] = 8'(rgb[23:16] + $urandom_range(6) - 3);
         cb = 16'(ca + $urandom_range(2000) - 1000);
         rb = 16'(ra + $urandom_range(2000) - 1000);
      end else begin
         cb = 16'($urandom); rb = 16'($urandom);
      end
      return make_item(rgb, ca, ra, cb, rb);
   endfunction

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_beta(input logic [23:0] b);
      csr_wen <= 1;
      csr_wdata <= b;
      @(posedge clock);
      csr_wen <= 0;
   endtask

   initial begin
      logic [23:0] beta_set[5];
      beta_set = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd1, 24'd3277};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: field extremes, equal pixels, huge exponent, tiny results
      send_item(make_item(48'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item({48{1'b1}}, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(make_item({24'hFFFFFF, 24'd0}, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
      send_item(make_item({24'd0, 24'hFFFFFF}, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
      send_item(make_item({24'h000000, 24'h010101}, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item({24'h141414, 24'h000000}, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item({24'h000000, 24'h000000}, 16'd1, 16'd0, 16'd0, 16'd0));
      send_item(make_item({24'h0A0B0C, 24'h0A0B0C}, 16'h8000, 16'd0, 16'd0, 16'h8000));
      send_item(make_item({24'h000015, 24'h000000}, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item({24'h101010, 24'h0F0F0F}, 16'h1234, 16'h5678, 16'h1230, 16'h5670));
      drain();
      // phases over beta settings, extremes included
      for (int p = 0; p < 5; p++) begin
         set_beta(p == 4 ? 24'($urandom) : beta_set[p]);
         calm_mode = (p == 2);
         for (int i = 0; i < 110; i++) begin
            if (p == 1 && i == 20) begin
               // receiver holds off while sender keeps offering
               fork
                  begin
                     hold_off = 1;
                     repeat (300) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            send_item(rand_item());
         end
         drain();
      end
      run_done = 1;
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
